FILE: hdl/tsu_pkg.sv
`default_nettype none

package tsu_pkg;

    localparam int MODE_W = 2;
    localparam int ADDR_W = 6;
    localparam int BUS_W  = 12;

    localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;

    localparam logic [ADDR_W-1:0] OFF_POWER   = 6'h00;
    localparam logic [ADDR_W-1:0] OFF_START   = 6'h04;
    localparam logic [ADDR_W-1:0] OFF_SELECT  = 6'h08;
    localparam logic [ADDR_W-1:0] OFF_RESULT  = 6'h10;
    localparam logic [ADDR_W-1:0] OFF_STATUS  = 6'h14;
    localparam logic [ADDR_W-1:0] OFF_COMPARE = 6'h18;
    localparam logic [ADDR_W-1:0] OFF_LOWER   = 6'h1C;
    localparam logic [ADDR_W-1:0] OFF_UPPER   = 6'h20;
    localparam logic [ADDR_W-1:0] OFF_ISTAT   = 6'h30;
    localparam logic [ADDR_W-1:0] OFF_IEN     = 6'h34;
    localparam logic [ADDR_W-1:0] OFF_ICLR    = 6'h38;

    // power control bits
    localparam int PWR_EN_BIT = 0;
    localparam int PWR_PD_BIT = 1;
    localparam logic [2:0] PWR_RESET = 3'b010;

    // average select sits at bit 9 on the bus
    localparam int SEL_AVG_BUS_BIT = 9;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] address;
        logic [BUS_W-1:0]  write_data;
        logic [BUS_W-1:0]  sample;
    } in_item_t;

    typedef struct packed {
        logic [BUS_W-1:0] read_data;
        logic             adc_irq;
        logic             cmp_irq;
        logic             busy_res;
    } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/tsu_stream_if.sv
`default_nettype none

interface tsu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/thermal_sensor_unit_registers.sv
// Thermal sensor unit, register view.
// req carries one item per handshake: a bus read, a bus write or a raw
// converter sample (mode, address, write_data, sample). rsp returns exactly
// one item per request: read_data for reads (zero otherwise), the two
// interrupt lines and the busy flag, all as they stand after that request.
// An accepted item is held in an input register; the register file and
// conversion logic then act on it and the result is loaded into the
// output register, from which rsp offers it. One item per cycle is
// sustained while rsp does not stall: the state update is a single
// combinational pass per item (the accumulate and count adds and the
// count and window compares).
// When rsp stalls, the output register holds and the input register fills;
// req.ready drops only while both are full.
// Reset (rst_n low, asynchronous) empties both stages, leaves the unit
// powered down with no conversion running and clears the other core registers.
`default_nettype none

module thermal_sensor_unit_registers #(
    parameter int CODE_WIDTH   = 12,
    parameter int MAX_AVG_LOG2 = 3
) (
    input wire logic    clk,
    input wire logic    rst_n,
    tsu_stream_if.sink   req,
    tsu_stream_if.source rsp
);
    import tsu_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t core_result;
    logic      advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_item_reg;

    tsu_core #(
        .CODE_WIDTH   (CODE_WIDTH),
        .MAX_AVG_LOG2 (MAX_AVG_LOG2)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            in_item_reg <= req.data;
        if (advance)
            out_item_reg <= core_result;
    end

endmodule

`default_nettype wire

FILE: hdl/tsu_core.sv
`default_nettype none

module tsu_core #(
    parameter int CODE_WIDTH   = 12,
    parameter int MAX_AVG_LOG2 = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire tsu_pkg::in_item_t item,
    output tsu_pkg::out_item_t     result
);
    import tsu_pkg::*;

    localparam int ACC_W = CODE_WIDTH + MAX_AVG_LOG2;
    localparam int CNT_W = MAX_AVG_LOG2 + 1;
    // the ADCT field is two bits wide, so a larger limit is clamped to 3
    localparam int ADCT_LIM = (MAX_AVG_LOG2 > 3) ? 3 : MAX_AVG_LOG2;
    localparam logic [1:0] ADCT_MAX = 2'(ADCT_LIM);

    logic [2:0]            pwr_reg, pwr_next;
    logic [2:0]            sel_reg, sel_next;
    logic [CODE_WIDTH-1:0] code_reg, code_next;
    logic                  running_reg, running_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [1:0]            cmp_reg, cmp_next;
    logic [CODE_WIDTH-1:0] lower_reg, lower_next;
    logic [CODE_WIDTH-1:0] upper_reg, upper_next;
    logic [1:0]            istat_reg, istat_next;
    logic [1:0]            ien_reg, ien_next;

    logic [ADDR_W-1:0]     off;
    logic [BUS_W-1:0]      rd;
    logic [BUS_W-1:0]      wd;
    logic [CODE_WIDTH-1:0] wd_code;
    logic [CODE_WIDTH-1:0] smp_code;
    logic                  unit_ready;
    logic [1:0]            n;
    logic [ACC_W-1:0]      acc_sum;
    logic [CNT_W:0]        cnt_sum;
    logic [CNT_W:0]        need;
    logic [CODE_WIDTH-1:0] new_code;
    logic                  in_window;

    assign off        = {item.address[ADDR_W-1:2], 2'b00};
    assign wd         = item.write_data;
    assign wd_code    = CODE_WIDTH'(item.write_data);
    assign smp_code   = CODE_WIDTH'(item.sample);
    assign unit_ready = pwr_reg[PWR_EN_BIT] & ~pwr_reg[PWR_PD_BIT];
    assign n          = (sel_reg[1:0] > ADCT_MAX) ? ADCT_MAX : sel_reg[1:0];
    assign acc_sum    = acc_reg + ACC_W'(smp_code);
    assign cnt_sum    = {1'b0, cnt_reg} + (CNT_W+1)'(1);
    assign need       = (CNT_W+1)'(1) << n;
    assign new_code   = sel_reg[2] ? CODE_WIDTH'(acc_sum >> n) : smp_code;
    assign in_window  = (new_code >= lower_reg) && (new_code <= upper_reg);

    always_comb
    begin
        pwr_next     = pwr_reg;
        sel_next     = sel_reg;
        code_next    = code_reg;
        running_next = running_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        cmp_next     = cmp_reg;
        lower_next   = lower_reg;
        upper_next   = upper_reg;
        istat_next   = istat_reg;
        ien_next     = ien_reg;
        rd           = '0;

        case (item.mode)
            MODE_READ:
            begin
                case (off)
                    OFF_POWER:   rd = BUS_W'(pwr_reg);
                    OFF_SELECT:
                    begin
                        rd = BUS_W'(sel_reg[1:0]);
                        rd[SEL_AVG_BUS_BIT] = sel_reg[2];
                    end
                    OFF_RESULT:  rd = BUS_W'(code_reg);
                    OFF_STATUS:  rd = BUS_W'(running_reg);
                    OFF_COMPARE: rd = BUS_W'(cmp_reg);
                    OFF_LOWER:   rd = BUS_W'(lower_reg);
                    OFF_UPPER:   rd = BUS_W'(upper_reg);
                    OFF_ISTAT:   rd = BUS_W'(istat_reg);
                    OFF_IEN:     rd = BUS_W'(ien_reg);
                    default:     rd = '0;
                endcase
            end
            MODE_WRITE:
            begin
                case (off)
                    OFF_POWER:
                    begin
                        pwr_next = wd[2:0];
                        if (!(wd[PWR_EN_BIT] && !wd[PWR_PD_BIT]))
                        begin
                            running_next = 1'b0;
                            cnt_next     = '0;
                            acc_next     = '0;
                        end
                    end
                    OFF_START:
                    begin
                        if (wd[0] && !running_reg && unit_ready)
                        begin
                            running_next = 1'b1;
                            cnt_next     = '0;
                            acc_next     = '0;
                        end
                    end
                    OFF_SELECT:  sel_next   = {wd[SEL_AVG_BUS_BIT], wd[1:0]};
                    OFF_COMPARE: cmp_next   = wd[1:0];
                    OFF_LOWER:   lower_next = wd_code;
                    OFF_UPPER:   upper_next = wd_code;
                    OFF_IEN:     ien_next   = wd[1:0];
                    OFF_ICLR:    istat_next = istat_reg & ~wd[1:0];
                    default:     ;
                endcase
            end
            MODE_SAMPLE:
            begin
                if (running_reg)
                begin
                    if (cnt_sum >= need)
                    begin
                        code_next     = new_code;
                        running_next  = 1'b0;
                        cnt_next      = '0;
                        acc_next      = '0;
                        istat_next[0] = 1'b1;
                        if (cmp_reg[0] && (cmp_reg[1] ? in_window : !in_window))
                            istat_next[1] = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                        cnt_next = cnt_sum[CNT_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        result.read_data = rd;
        result.adc_irq   = istat_next[0] & ien_next[0];
        result.cmp_irq   = istat_next[1] & ien_next[1];
        result.busy_res  = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwr_reg     <= PWR_RESET;
            sel_reg     <= '0;
            code_reg    <= '0;
            running_reg <= 1'b0;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            cmp_reg     <= '0;
            lower_reg   <= '0;
            upper_reg   <= '0;
            istat_reg   <= '0;
            ien_reg     <= '0;
        end
        else if (step)
        begin
            pwr_reg     <= pwr_next;
            sel_reg     <= sel_next;
            code_reg    <= code_next;
            running_reg <= running_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            cmp_reg     <= cmp_next;
            lower_reg   <= lower_next;
            upper_reg   <= upper_next;
            istat_reg   <= istat_next;
            ien_reg     <= ien_next;
        end
    end

endmodule

`default_nettype wire
